/* hdl/mng_pkg.sv */
// ----------------------------------------------------------------------------
// mng_pkg
// Shared constants, types and the gamma threshold table for the peak
// normalising gamma 2.2 encoder.
// ----------------------------------------------------------------------------
package mng_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int RATIO_BITS  = 12;

    localparam int CAPACITY    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CHAN_W      = 32;
    localparam int PIX_W       = 3 * CHAN_W;
    localparam int RATIO_W     = RATIO_BITS + 1;
    localparam int DIV_STEPS   = RATIO_BITS + 1;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int CODE_W      = 8;
    localparam int CODES       = 1 << CODE_W;
    localparam int DIM_W       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int BIG_W       = 192;

    // action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EMIT = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    typedef logic [RATIO_W-1:0] t_ratio;
    typedef t_ratio [CODES-1:0] t_thr_tab;

    // one emitted pixel on its way from front to back
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] peak;
        logic              last;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_GAM,
        S_HOLD
    } t_back_state;

    // smallest ratio r with r^5 * 255^11 >= v^11 * 2^(5*RATIO_BITS), for every code v
    function automatic t_thr_tab build_thr();
        t_thr_tab          tab;
        logic [BIG_W-1:0]  k255;
        logic [BIG_W-1:0]  lhs;
        logic [BIG_W-1:0]  rhs;
        int                lo;
        int                hi;
        int                mid;
        k255 = BIG_W'(1);
        for (int i = 0; i < 11; i++) k255 = k255 * BIG_W'(255);
        for (int v = 0; v < CODES; v++) begin
            lhs = BIG_W'(1);
            for (int i = 0; i < 11; i++) lhs = lhs * BIG_W'(v);
            lhs = lhs << (5 * RATIO_BITS);
            lo = 0;
            hi = 1 << RATIO_BITS;
            for (int s = 0; s < RATIO_W; s++) begin
                if (lo < hi) begin
                    mid = (lo + hi) >> 1;
                    rhs = k255;
                    for (int i = 0; i < 5; i++) rhs = rhs * BIG_W'(mid);
                    if (rhs >= lhs) hi = mid;
                    else lo = mid + 1;
                end
            end
            tab[v] = RATIO_W'(lo);
        end
        return tab;
    endfunction

    localparam t_thr_tab GAMMA_THR = build_thr();

endpackage

/* hdl/mng_if.sv */
// ----------------------------------------------------------------------------
// mng_if
// Channel interfaces: pixel input, encoded result output, register writes.
// ----------------------------------------------------------------------------
interface mng_pix_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [mng_pkg::CHAN_W-1:0]  red_in;
    logic [mng_pkg::CHAN_W-1:0]  green_in;
    logic [mng_pkg::CHAN_W-1:0]  blue_in;
    modport source (output valid, action, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, action, red_in, green_in, blue_in, output ready);
endinterface

interface mng_res_if;
    logic                        valid;
    logic                        ready;
    logic [mng_pkg::CODE_W-1:0]  red_out;
    logic [mng_pkg::CODE_W-1:0]  green_out;
    logic [mng_pkg::CODE_W-1:0]  blue_out;
    logic                        frame_end;
    modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface mng_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mng_pkg::CFG_IDX_W-1:0]  index;
    logic [mng_pkg::DIM_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/mng_ram.sv */
// ----------------------------------------------------------------------------
// mng_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mng_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/mng_front.sv */
// ----------------------------------------------------------------------------
// mng_front
// Accepts items and register writes, tracks frame counters and peak, stores
// pixels and fetches the pixel of each valid emit request into the queue.
// ----------------------------------------------------------------------------
module mng_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mng_pix_if.sink       i_pix,
    mng_cfg_if.sink       i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output mng_pkg::t_job o_job
);

    logic [mng_pkg::DIM_W-1:0]  r_width;
    logic [mng_pkg::DIM_W-1:0]  r_height;
    logic [mng_pkg::CNT_W-1:0]  r_loaded, n_loaded;
    logic [mng_pkg::CNT_W-1:0]  r_emit, n_emit;
    logic [mng_pkg::CHAN_W-1:0] r_peak, n_peak;
    logic                       r_pend, n_pend;
    logic [mng_pkg::CHAN_W-1:0] r_pend_peak, n_pend_peak;
    logic                       r_pend_last, n_pend_last;

    logic [mng_pkg::CNT_W-1:0]  w_dim;
    logic [mng_pkg::CNT_W-1:0]  h_dim;
    logic [mng_pkg::CNT_W-1:0]  total;
    logic                       accept;
    logic                       we;
    logic                       re;
    logic [mng_pkg::ADDR_W-1:0] raddr;
    logic [mng_pkg::CHAN_W-1:0] pmax;
    logic [mng_pkg::PIX_W-1:0]  rdata;
    logic                       last;

    function automatic logic [mng_pkg::CNT_W-1:0] clamp_dim(
        input logic [mng_pkg::DIM_W-1:0] v,
        input int                        maxv
    );
        if (v == '0) return mng_pkg::CNT_W'(1);
        if (int'(v) > maxv) return mng_pkg::CNT_W'(maxv);
        return mng_pkg::CNT_W'(v);
    endfunction

    // frame size from the registers
    assign w_dim = clamp_dim(r_width, mng_pkg::MAX_WIDTH);
    assign h_dim = clamp_dim(r_height, mng_pkg::MAX_HEIGHT);
    assign total = mng_pkg::CNT_W'(w_dim * h_dim);

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = !r_pend && !i_q_full;
    assign accept      = i_pix.valid && i_pix.ready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= mng_pkg::DIM_W'(256);
            r_height <= mng_pkg::DIM_W'(256);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mng_pkg::REG_FRAME_WIDTH:  r_width  <= i_cfg.data;
                mng_pkg::REG_FRAME_HEIGHT: r_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // largest of the incoming channels and the running peak
    always_comb begin
        pmax = r_peak;
        if (i_pix.red_in   > pmax) pmax = i_pix.red_in;
        if (i_pix.green_in > pmax) pmax = i_pix.green_in;
        if (i_pix.blue_in  > pmax) pmax = i_pix.blue_in;
    end

    assign raddr = (r_emit >= mng_pkg::CNT_W'(mng_pkg::CAPACITY))
                 ? mng_pkg::ADDR_W'(mng_pkg::CAPACITY - 1) : r_emit[mng_pkg::ADDR_W-1:0];
    assign last  = (r_emit + mng_pkg::CNT_W'(1)) >= total;

    // item classification and counter update
    always_comb begin
        n_loaded    = r_loaded;
        n_emit      = r_emit;
        n_peak      = r_peak;
        n_pend      = 1'b0;
        n_pend_peak = r_pend_peak;
        n_pend_last = r_pend_last;
        we          = 1'b0;
        re          = 1'b0;
        if (accept) begin
            unique case (i_pix.action)
                mng_pkg::ACT_LOAD: begin
                    if (r_loaded < total) begin
                        we       = 1'b1;
                        n_peak   = pmax;
                        n_loaded = r_loaded + mng_pkg::CNT_W'(1);
                    end
                end
                mng_pkg::ACT_EMIT: begin
                    if (r_loaded >= total) begin
                        re          = 1'b1;
                        n_pend      = 1'b1;
                        n_pend_peak = r_peak;
                        n_pend_last = last;
                        if (last) begin
                            n_peak   = '0;
                            n_loaded = '0;
                            n_emit   = '0;
                        end else begin
                            n_emit = r_emit + mng_pkg::CNT_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_emit   <= '0;
            r_peak   <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_loaded <= n_loaded;
            r_emit   <= n_emit;
            r_peak   <= n_peak;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_peak <= n_pend_peak;
        r_pend_last <= n_pend_last;
    end

    // frame store
    mng_ram #(
        .WIDTH (mng_pkg::PIX_W),
        .DEPTH (mng_pkg::CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_loaded[mng_pkg::ADDR_W-1:0]),
        .i_wdata ({i_pix.red_in, i_pix.green_in, i_pix.blue_in}),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // fetched pixel goes into the queue the cycle after the request
    assign o_push      = r_pend;
    assign o_job.red   = rdata[3*mng_pkg::CHAN_W-1:2*mng_pkg::CHAN_W];
    assign o_job.green = rdata[2*mng_pkg::CHAN_W-1:mng_pkg::CHAN_W];
    assign o_job.blue  = rdata[mng_pkg::CHAN_W-1:0];
    assign o_job.peak  = r_pend_peak;
    assign o_job.last  = r_pend_last;

endmodule

/* hdl/mng_queue.sv */
// ----------------------------------------------------------------------------
// mng_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module mng_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mng_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output mng_pkg::t_job o_job
);

    localparam int PTR_W = $clog2(mng_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mng_pkg::QUEUE_DEPTH + 1);

    mng_pkg::t_job    r_mem [mng_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_pop;

    assign o_full  = r_cnt == CNT_W'(mng_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(mng_pkg::QUEUE_DEPTH - 1)) return '0;
        return p + PTR_W'(1);
    endfunction

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= wrap_inc(r_wp);
            if (do_pop) r_rp <= wrap_inc(r_rp);
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hdl/mng_back.sv */
// ----------------------------------------------------------------------------
// mng_back
// Divides the three channels by the peak, one quotient bit a cycle in three
// lanes, then finds each gamma code bit by bit from the threshold table.
// ----------------------------------------------------------------------------
module mng_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  mng_pkg::t_job i_job,
    output logic          o_pop,
    mng_res_if.source     o_res
);

    localparam int REM_W = mng_pkg::CHAN_W + 1;
    localparam int BIT_W = $clog2(mng_pkg::CODE_W);

    mng_pkg::t_back_state       r_state, n_state;
    logic [REM_W-1:0]           r_rem [3];
    logic [REM_W-1:0]           n_rem [3];
    logic [mng_pkg::RATIO_W-1:0] r_q [3];
    logic [mng_pkg::RATIO_W-1:0] n_q [3];
    logic [mng_pkg::CODE_W-1:0] r_v [3];
    logic [mng_pkg::CODE_W-1:0] n_v [3];
    logic [mng_pkg::CHAN_W-1:0] r_peak, n_peak;
    logic                       r_last, n_last;
    logic [mng_pkg::STEP_W-1:0] r_step, n_step;
    logic [BIT_W-1:0]           r_bit, n_bit;
    logic                       r_ovalid, n_ovalid;
    logic [mng_pkg::CODE_W-1:0] r_out [3];
    logic [mng_pkg::CODE_W-1:0] n_out [3];
    logic                       r_oend, n_oend;

    logic [REM_W-1:0]           diff [3];
    logic [mng_pkg::CODE_W-1:0] cand [3];
    logic                       out_free;

    localparam mng_pkg::t_ratio FULL = mng_pkg::RATIO_W'(1 << mng_pkg::RATIO_BITS);

    assign out_free = !r_ovalid || o_res.ready;

    // sequencer and lanes
    always_comb begin
        n_state  = r_state;
        n_peak   = r_peak;
        n_last   = r_last;
        n_step   = r_step;
        n_bit    = r_bit;
        n_ovalid = r_ovalid && !o_res.ready;
        n_oend   = r_oend;
        o_pop    = 1'b0;
        for (int c = 0; c < 3; c++) begin
            n_rem[c] = r_rem[c];
            n_q[c]   = r_q[c];
            n_v[c]   = r_v[c];
            n_out[c] = r_out[c];
            diff[c]  = r_rem[c] - {1'b0, r_peak};
            cand[c]  = r_v[c] | mng_pkg::CODE_W'(1 << r_bit);
        end
        unique case (r_state)
            mng_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_pop    = 1'b1;
                    n_rem[0] = {1'b0, i_job.red};
                    n_rem[1] = {1'b0, i_job.green};
                    n_rem[2] = {1'b0, i_job.blue};
                    n_peak   = i_job.peak;
                    n_last   = i_job.last;
                    n_step   = '0;
                    for (int c = 0; c < 3; c++) n_q[c] = '0;
                    n_state  = mng_pkg::S_DIV;
                end
            end
            mng_pkg::S_DIV: begin
                // restoring division, one quotient bit per lane
                for (int c = 0; c < 3; c++) begin
                    if (r_rem[c] >= {1'b0, r_peak}) begin
                        n_rem[c] = {diff[c][REM_W-2:0], 1'b0};
                        n_q[c]   = {r_q[c][mng_pkg::RATIO_W-2:0], 1'b1};
                    end else begin
                        n_rem[c] = {r_rem[c][REM_W-2:0], 1'b0};
                        n_q[c]   = {r_q[c][mng_pkg::RATIO_W-2:0], 1'b0};
                    end
                end
                n_step = r_step + mng_pkg::STEP_W'(1);
                if (r_step == mng_pkg::STEP_W'(mng_pkg::DIV_STEPS - 1)) begin
                    n_state = mng_pkg::S_GAM;
                    n_bit   = BIT_W'(mng_pkg::CODE_W - 1);
                    for (int c = 0; c < 3; c++) n_v[c] = '0;
                end
            end
            mng_pkg::S_GAM: begin
                // code search, most significant bit first; ratio saturates at full scale
                for (int c = 0; c < 3; c++) begin
                    if (mng_pkg::GAMMA_THR[cand[c]] <= ((r_q[c] > FULL) ? FULL : r_q[c]))
                        n_v[c] = cand[c];
                end
                n_bit = r_bit - BIT_W'(1);
                if (r_bit == '0) n_state = mng_pkg::S_HOLD;
            end
            mng_pkg::S_HOLD: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oend   = r_last;
                    for (int c = 0; c < 3; c++)
                        n_out[c] = (r_peak == '0) ? '0 : r_v[c];
                    n_state  = mng_pkg::S_IDLE;
                end
            end
            default: n_state = mng_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mng_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_peak <= n_peak;
        r_last <= n_last;
        r_step <= n_step;
        r_bit  <= n_bit;
        r_oend <= n_oend;
        for (int c = 0; c < 3; c++) begin
            r_rem[c] <= n_rem[c];
            r_q[c]   <= n_q[c];
            r_v[c]   <= n_v[c];
            r_out[c] <= n_out[c];
        end
    end

    // result register
    assign o_res.valid     = r_ovalid;
    assign o_res.red_out   = r_out[0];
    assign o_res.green_out = r_out[1];
    assign o_res.blue_out  = r_out[2];
    assign o_res.frame_end = r_oend;

endmodule

/* hdl/max_normalize_gamma_encode.sv */
// ----------------------------------------------------------------------------
// max_normalize_gamma_encode
// Peak normalised gamma 2.2 tone map over a stored frame of Q16.16 RGB pixels.
//
//   channel  role    carries
//   i_pix    sink    action, red_in, green_in, blue_in
//   o_res    source  red_out, green_out, blue_out, frame_end
//   i_cfg    sink    index (0 frame_width, 1 frame_height), data; always ready
//
// A load writes the pixel to the store. An emit fetches the pixel in the
// front and queues it; the back takes it, divides it into 13 quotient bits
// with its bit-serial dividers, searches the 8 code bits and registers the
// result. The front queues up to two fetched pixels; loads and requests stall
// on a full queue and for the cycle after each request that is served.
// Reset is synchronous active low; the frame store needs no clearing.
// ----------------------------------------------------------------------------
module max_normalize_gamma_encode (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mng_pix_if.sink   i_pix,
    mng_cfg_if.sink   i_cfg,
    mng_res_if.source o_res
);

    mng_pkg::t_job push_job;
    mng_pkg::t_job pop_job;
    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          pop;

    // front: classification, counters, store
    mng_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    // decoupling queue
    mng_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (pop_job)
    );

    // back: division and gamma encode
    mng_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (pop_job),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule

/* sim/tb_max_normalize_gamma_encode.sv */
// ----------------------------------------------------------------------------
// tb_max_normalize_gamma_encode
// Self-checking bench for the peak normalising gamma 2.2 encoder. Frames of
// pixels are loaded and then emitted under random idling on both channels.
// Each emitted item is checked against a predictor of the frame store, peak
// tracking and exact integer gamma search, or against fixed directed codes.
// Frame size registers are rewritten between frames, the extremes among them.
// ----------------------------------------------------------------------------
module tb_max_normalize_gamma_encode;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_code_px;

    typedef struct {
        logic        action;
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        bit          typed;
        t_code_px    want;
    } t_row;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 40;

    logic i_clk;
    logic i_rst_n;

    mng_pix_if pix ();
    mng_res_if res ();
    mng_cfg_if cfg ();

    max_normalize_gamma_encode u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // predictor state
    logic [31:0] px_red   [0:mng_pkg::CAPACITY-1];
    logic [31:0] px_green [0:mng_pkg::CAPACITY-1];
    logic [31:0] px_blue  [0:mng_pkg::CAPACITY-1];
    logic [31:0] peak_seen;
    int          pixels_loaded;
    int          next_emit;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;

    t_code_px    pending_px [$];
    int          errors;
    int          cycles;
    int          results_seen;
    bit          no_idle;
    bit          hold_done;

    // clock and cycle limit
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int clamp_dim(logic [8:0] v);
        if (v < 1) return 1;
        return (v > 256) ? 256 : int'(v);
    endfunction

    function automatic int frame_pixels();
        return clamp_dim(width_reg) * clamp_dim(height_reg);
    endfunction

    // largest v with v^11 * 2^(5*RATIO_BITS) <= ratio^5 * 255^11
    function automatic logic [7:0] gamma_code(logic [31:0] chan, logic [31:0] peak);
        logic [63:0]  ratio;
        logic [191:0] rhs;
        logic [191:0] lhs;
        int           lo;
        int           hi;
        int           mid;
        if (peak == 0) return 8'd0;
        ratio = {chan, 12'b0};
        ratio = ratio / peak;
        if (ratio > 64'd4096) ratio = 64'd4096;
        rhs = 192'd1;
        for (int i = 0; i < 5; i++) rhs = rhs * ratio;
        for (int i = 0; i < 11; i++) rhs = rhs * 192'd255;
        lo = 0;
        hi = 255;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = 192'd1;
            for (int i = 0; i < 11; i++) lhs = lhs * 192'(mid);
            lhs = lhs << (5 * mng_pkg::RATIO_BITS);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return 8'(lo);
    endfunction

    // advance the predictor by one accepted item; returns 1 with a result
    function automatic bit tone_map_step(logic act, logic [31:0] r, logic [31:0] g,
                                         logic [31:0] b, output t_code_px px);
        int total;
        total = frame_pixels();
        px = '{default: '0};
        if (act == mng_pkg::ACT_LOAD) begin
            if (pixels_loaded >= total) return 0;
            px_red[pixels_loaded]   = r;
            px_green[pixels_loaded] = g;
            px_blue[pixels_loaded]  = b;
            if (r > peak_seen) peak_seen = r;
            if (g > peak_seen) peak_seen = g;
            if (b > peak_seen) peak_seen = b;
            pixels_loaded++;
            return 0;
        end
        if (pixels_loaded < total) return 0;
        px.red       = gamma_code(px_red[next_emit], peak_seen);
        px.green     = gamma_code(px_green[next_emit], peak_seen);
        px.blue      = gamma_code(px_blue[next_emit], peak_seen);
        px.frame_end = (next_emit + 1 >= total);
        if (px.frame_end) begin
            peak_seen     = '0;
            pixels_loaded = 0;
            next_emit     = 0;
        end else begin
            next_emit++;
        end
        return 1;
    endfunction

    // offer one item and record its expected result on acceptance
    task automatic send_pixel(logic act, logic [31:0] r, logic [31:0] g, logic [31:0] b,
                              bit typed = 0, t_code_px want = '{default: '0});
        int       gap;
        t_code_px px;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid    <= 1'b1;
        pix.action   <= act;
        pix.red_in   <= r;
        pix.green_in <= g;
        pix.blue_in  <= b;
        do @(posedge i_clk); while (!pix.ready);
        if (tone_map_step(act, r, g, b, px)) pending_px.push_back(typed ? want : px);
    endtask

    // let the block drain before touching the registers
    task automatic wait_idle();
        pix.valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [mng_pkg::CFG_IDX_W-1:0] idx, logic [8:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        if (idx == mng_pkg::REG_FRAME_WIDTH) width_reg = val;
        else height_reg = val;
    endtask

    task automatic set_frame(logic [8:0] w, logic [8:0] h);
        wait_idle();
        write_reg(mng_pkg::REG_FRAME_WIDTH, w);
        write_reg(mng_pkg::REG_FRAME_HEIGHT, h);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_chan(int style);
        case (style)
            0: return $urandom();
            1: return $urandom_range(0, 255);
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    // one whole frame, sometimes with early requests or surplus loads
    task automatic run_frame(output int sent);
        int total;
        int style;
        total = frame_pixels();
        sent  = 0;
        style = $urandom_range(0, 9);
        if ($urandom_range(0, 9) == 0) begin
            send_pixel(mng_pkg::ACT_EMIT, $urandom(), $urandom(), $urandom());
            sent++;
        end
        for (int i = 0; i < total; i++) begin
            if (style == 2 || style > 4)
                send_pixel(mng_pkg::ACT_LOAD, rand_chan(style), rand_chan(style),
                           rand_chan(style));
            else
                send_pixel(mng_pkg::ACT_LOAD, rand_chan($urandom_range(0, 4)),
                           rand_chan($urandom_range(0, 4)), rand_chan($urandom_range(0, 4)));
            sent++;
            if ($urandom_range(0, 30) == 0) begin
                send_pixel(mng_pkg::ACT_EMIT, $urandom(), $urandom(), $urandom());
                sent++;
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            send_pixel(mng_pkg::ACT_LOAD, $urandom(), $urandom(), $urandom());
            sent++;
        end
        for (int i = 0; i < total; i++) begin
            send_pixel(mng_pkg::ACT_EMIT, $urandom(), $urandom(), $urandom());
            sent++;
            if ($urandom_range(0, 20) == 0) begin
                send_pixel(mng_pkg::ACT_LOAD, $urandom(), $urandom(), $urandom());
                sent++;
            end
        end
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        int n;
        res.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 3);
            if (!hold_done && results_seen >= 200) begin
                n = 400;
                hold_done = 1;
            end
            if (n > 0) begin
                res.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (!(res.valid && res.ready));
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_code_px want;
        if (i_rst_n && res.valid && res.ready) begin
            results_seen <= results_seen + 1;
            if (pending_px.size() == 0) begin
                $error("result with no expectation waiting");
                errors++;
            end else begin
                want = pending_px.pop_front();
                if (res.red_out !== want.red) begin
                    $error("red_out expected %0d got %0d", want.red, res.red_out);
                    errors++;
                end
                if (res.green_out !== want.green) begin
                    $error("green_out expected %0d got %0d", want.green, res.green_out);
                    errors++;
                end
                if (res.blue_out !== want.blue) begin
                    $error("blue_out expected %0d got %0d", want.blue, res.blue_out);
                    errors++;
                end
                if (res.frame_end !== want.frame_end) begin
                    $error("frame_end expected %0d got %0d", want.frame_end, res.frame_end);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_row directed [$];
        int   sent;
        int   items;
        errors        = 0;
        cycles        = 0;
        results_seen  = 0;
        no_idle       = 0;
        hold_done     = 0;
        peak_seen     = '0;
        pixels_loaded = 0;
        next_emit     = 0;
        width_reg     = 9'd256;
        height_reg    = 9'd256;
        i_rst_n      <= 1'b0;
        pix.valid    <= 1'b0;
        pix.action   <= mng_pkg::ACT_LOAD;
        pix.red_in   <= '0;
        pix.green_in <= '0;
        pix.blue_in  <= '0;
        cfg.valid    <= 1'b0;
        cfg.index    <= mng_pkg::REG_FRAME_WIDTH;
        cfg.data     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single pixel frame: zero registers clamp to one
        set_frame(9'd0, 9'd0);
        directed = '{
            '{mng_pkg::ACT_EMIT, 32'h1, 32'h2, 32'h3, 0, '{0, 0, 0, 0}},
            '{mng_pkg::ACT_LOAD, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 0, '{0, 0, 0, 0}},
            '{mng_pkg::ACT_LOAD, 32'h1, 32'h2, 32'h3, 0, '{0, 0, 0, 0}},
            '{mng_pkg::ACT_EMIT, 32'h0, 32'h0, 32'h0, 1, '{255, 0, 255, 1}},
            '{mng_pkg::ACT_LOAD, 32'h0, 32'h0, 32'h0, 0, '{0, 0, 0, 0}},
            '{mng_pkg::ACT_EMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
              '{0, 0, 0, 1}},
            '{mng_pkg::ACT_LOAD, 32'h0001_0000, 32'h1, 32'h0000_8000, 0, '{0, 0, 0, 0}},
            '{mng_pkg::ACT_EMIT, 32'h0, 32'h0, 32'h0, 0, '{0, 0, 0, 0}},
            '{mng_pkg::ACT_LOAD, 32'h7, 32'h7, 32'h7, 0, '{0, 0, 0, 0}},
            '{mng_pkg::ACT_EMIT, 32'h0, 32'h0, 32'h0, 1, '{255, 255, 255, 1}}
        };
        foreach (directed[i])
            send_pixel(directed[i].action, directed[i].red, directed[i].green,
                       directed[i].blue, directed[i].typed, directed[i].want);

        // two by two frame with a spread of magnitudes
        set_frame(9'd2, 9'd2);
        directed = '{
            '{mng_pkg::ACT_LOAD, 32'h8000_0000, 32'h4000_0000, 32'h0000_0001, 0,
              '{0, 0, 0, 0}},
            '{mng_pkg::ACT_LOAD, 32'h0, 32'hFFFF_FFFE, 32'h1234_5678, 0, '{0, 0, 0, 0}},
            '{mng_pkg::ACT_LOAD, 32'h00FF_FFFF, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 0,
              '{0, 0, 0, 0}},
            '{mng_pkg::ACT_LOAD, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF, 0,
              '{0, 0, 0, 0}},
            '{mng_pkg::ACT_EMIT, 32'h0, 32'h0, 32'h0, 0, '{0, 0, 0, 0}},
            '{mng_pkg::ACT_EMIT, 32'h0, 32'h0, 32'h0, 0, '{0, 0, 0, 0}},
            '{mng_pkg::ACT_EMIT, 32'h0, 32'h0, 32'h0, 0, '{0, 0, 0, 0}},
            '{mng_pkg::ACT_EMIT, 32'h0, 32'h0, 32'h0, 0, '{0, 0, 0, 0}}
        };
        foreach (directed[i])
            send_pixel(directed[i].action, directed[i].red, directed[i].green,
                       directed[i].blue, directed[i].typed, directed[i].want);

        // extreme shapes: full width row, full height column, oversize registers
        items = 0;
        set_frame(9'd256, 9'd1);
        run_frame(sent);
        items += sent;
        set_frame(9'd1, 9'd511);
        run_frame(sent);
        items += sent;
        set_frame(9'd511, 9'd0);
        run_frame(sent);
        items += sent;

        // random frames, mostly small
        while (items < 2000) begin
            if ($urandom_range(0, 9) == 0)
                set_frame(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)));
            else
                set_frame(9'($urandom_range(1, 6)), 9'($urandom_range(1, 6)));
            no_idle = ($urandom_range(0, 4) == 0);
            run_frame(sent);
            items += sent;
        end
        no_idle = 0;

        pix.valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
